@@ rtl/irt_pkg.sv @@
`timescale 1ns / 1ps

package irt_pkg;

	// field widths fixed by the stream format
	localparam int IN_COORD_W = 32;
	localparam int STATUS_W   = 2;
	localparam int USED_W     = 7;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 16;

	// parameter defaults
	localparam int CAPACITY_DEF    = 64;
	localparam int COORD_WIDTH_DEF = 32;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_ACCEPT  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [USED_W-1:0]   used_t;

endpackage

@@ rtl/interval_reservation_table_core.sv @@
`timescale 1ns / 1ps

// interval reservation table with overlap check
// slave channel (s_*): one beat is one request for the half-open range
//   [range_start, range_end); s_tready is high only while the block is idle
// master channel (m_*): one beat per request carrying the status
//   (accepted, overlap, table full) and the number of stored entries after it
// a request walks all stored entries through one comparator pair, reading
//   one entry per cycle from the entry memory (registered read port)
// a request moves the sequencer from idle to scan and then to done, where the
//   result register is loaded and the sequencer returns to idle
// one request at a time: s_tready comes back high as the result appears, so
//   the next request is not taken before the previous one is through
// the result sits in an output register; the next request is taken while it
//   waits, and the scan of that request stalls only at its final step until
//   the previous result has been taken
// reset clears the entry count and the handshake state; the entry memory is
//   not cleared, since only entries below the count are ever read
// entries are never removed: once full, every non-overlapping request
//   gets the table-full status
module interval_reservation_table_core #(
	parameter int CAPACITY    = irt_pkg::CAPACITY_DEF,
	parameter int COORD_WIDTH = irt_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [irt_pkg::S_TDATA_W-1:0] s_tdata, // range_start, range_end
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [irt_pkg::M_TDATA_W-1:0] m_tdata  // status, used_entries, zero pad
);

	import irt_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PAD_W  = M_TDATA_W - STATUS_W - USED_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;    // stored entries
	logic [CNT_W-1:0]       issue_q;    // next entry to read
	logic                   rd_vld_s1;  // read data valid this cycle
	logic                   hit_q;
	logic [COORD_WIDTH-1:0] req_start_q;
	logic [COORD_WIDTH-1:0] req_end_q;

	logic                   out_vld_q;
	status_t                out_status_q;
	used_t                  out_used_q;

	logic                   in_beat;
	logic                   out_free;
	logic                   finish;
	logic                   issue;
	logic                   do_store;
	status_t                next_status;
	logic [CNT_W-1:0]       next_count;

	logic [COORD_WIDTH-1:0] ent_start;
	logic [COORD_WIDTH-1:0] ent_end;
	logic                   ent_hit;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign finish   = (state_q == ST_DONE) && out_free;

	// one read issued per cycle until every stored entry has gone out
	assign issue = (state_q == ST_SCAN) && (issue_q != count_q);

	// overlap wins over a full table
	always_comb begin
		next_status = STATUS_ACCEPT;
		do_store    = 1'b0;
		if (hit_q) begin
			next_status = STATUS_OVERLAP;
		end else if (count_q >= CNT_W'(CAPACITY)) begin
			next_status = STATUS_FULL;
		end else begin
			do_store = 1'b1;
		end
	end

	assign next_count = do_store ? count_q + 1'b1 : count_q;

	irt_store #(
		.CAPACITY    (CAPACITY),
		.COORD_WIDTH (COORD_WIDTH),
		.ADDR_W      (ADDR_W)
	) u_store (
		.clk      (clk),
		.wr_en    (finish && do_store),
		.wr_addr  (count_q[ADDR_W-1:0]),
		.wr_start (req_start_q),
		.wr_end   (req_end_q),
		.rd_addr  (issue_q[ADDR_W-1:0]),
		.rd_start (ent_start),
		.rd_end   (ent_end)
	);

	// the one shared comparator pair
	irt_cmp #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_cmp (
		.req_start (req_start_q),
		.req_end   (req_end_q),
		.ent_start (ent_start),
		.ent_end   (ent_end),
		.hit       (ent_hit)
	);

	// request latch, coordinates taken modulo 2^COORD_WIDTH
	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_start_q <= COORD_WIDTH'(s_tdata[IN_COORD_W-1:0]);
			req_end_q   <= COORD_WIDTH'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					hit_q   <= 1'b0;
					if (in_beat) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rd_vld_s1 && ent_hit) begin
						hit_q <= 1'b1;
					end
					// last compare has landed
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						count_q <= next_count;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= next_status;
			out_used_q   <= USED_W'(next_count);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_used_q, out_status_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_store_grows: assert property (@(posedge clk) disable iff (!arst_n)
		finish && (next_status == STATUS_ACCEPT) |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted request did not grow the table");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rd_vld_s1 && !issue)
		else $error("entry read while idle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status_q == STATUS_FULL) |-> count_q == CNT_W'(CAPACITY))
		else $error("table-full status with room left");

endmodule

@@ rtl/irt_store.sv @@
`timescale 1ns / 1ps

module irt_store #(
	parameter int CAPACITY    = 64,
	parameter int COORD_WIDTH = 32,
	parameter int ADDR_W      = 6
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  logic [COORD_WIDTH-1:0] wr_start,
	input  logic [COORD_WIDTH-1:0] wr_end,
	input  logic [ADDR_W-1:0]      rd_addr,
	output logic [COORD_WIDTH-1:0] rd_start,
	output logic [COORD_WIDTH-1:0] rd_end
);

	logic [COORD_WIDTH-1:0] start_mem [CAPACITY];
	logic [COORD_WIDTH-1:0] end_mem   [CAPACITY];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= wr_start;
			end_mem[wr_addr]   <= wr_end;
		end
		rd_start <= start_mem[rd_addr];
		rd_end   <= end_mem[rd_addr];
	end

endmodule

@@ rtl/irt_cmp.sv @@
`timescale 1ns / 1ps

module irt_cmp #(
	parameter int COORD_WIDTH = 32
) (
	input  logic [COORD_WIDTH-1:0] req_start,
	input  logic [COORD_WIDTH-1:0] req_end,
	input  logic [COORD_WIDTH-1:0] ent_start,
	input  logic [COORD_WIDTH-1:0] ent_end,
	output logic                   hit
);

	// half-open ranges overlap when each starts before the other ends
	assign hit = (ent_start < req_end) && (ent_end > req_start);

endmodule

@@ tb/sv/tb_interval_reservation_table_core.sv @@
`timescale 1ns / 1ps

module tb_interval_reservation_table_core;

	import irt_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int TABLE_DEPTH  = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1238;
	localparam int CALM_ITEMS   = 150;  // tail of the run with no idling on either side
	localparam int HOLD_AT      = 300;  // random item at which the long hold-off is asked for
	localparam int LONG_HOLD    = 400;  // cycles the result side holds off
	localparam int PAD_W        = M_TDATA_W - STATUS_W - USED_W;

	typedef struct packed {
		status_t status;
		used_t   used;
	} booking_t;

	typedef struct {
		logic [IN_COORD_W-1:0] lo;
		logic [IN_COORD_W-1:0] hi;
		bit                    fixed;   // expected result typed in below
		booking_t              result;
	} request_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // range_start, range_end
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // status, used_entries, zero pad

	// reservations the table should hold, in order of booking
	logic [IN_COORD_W-1:0] booked_lo[$];
	logic [IN_COORD_W-1:0] booked_hi[$];
	booking_t              owed_results[$];

	int  fail_count = 0;
	int  beat_count = 0;
	bit  calm = 1'b0;
	bit  hold_off_due = 1'b0;

	interval_reservation_table_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// overlap first, then room, else append
	function automatic booking_t book_range(input logic [IN_COORD_W-1:0] lo,
			input logic [IN_COORD_W-1:0] hi);
		booking_t r;
		bit clash;
		clash = 1'b0;
		foreach (booked_lo[k])
			if (booked_lo[k] < hi && booked_hi[k] > lo)
				clash = 1'b1;
		if (clash) begin
			r.status = STATUS_OVERLAP;
		end else if (booked_lo.size() >= TABLE_DEPTH) begin
			r.status = STATUS_FULL;
		end else begin
			booked_lo.push_back(lo);
			booked_hi.push_back(hi);
			r.status = STATUS_ACCEPT;
		end
		r.used = used_t'(booked_lo.size());
		return r;
	endfunction

	// mix of hits on stored ranges, edge-touching neighbors, fresh ranges,
	// empty or inverted ranges and raw noise
	function automatic void draw_request(output logic [IN_COORD_W-1:0] lo,
			output logic [IN_COORD_W-1:0] hi);
		int unsigned pick;
		int unsigned k;
		int unsigned d;
		logic [IN_COORD_W-1:0] p;
		logic [IN_COORD_W:0]   sum;
		pick = $urandom_range(0, 99);
		if (booked_lo.size() == 0 && pick < 70)
			pick = 70;
		k = (booked_lo.size() == 0) ? 0 : $urandom_range(0, booked_lo.size() - 1);
		if (pick < 40) begin
			// land inside a stored range, degenerate entries are reused as they are
			lo = booked_lo[k];
			hi = booked_hi[k];
			if (lo < hi) begin
				p = lo + $urandom_range(0, hi - lo - 1);
				d = $urandom_range(0, 255);
				lo = (p > d) ? p - d : '0;
				sum = {1'b0, p} + 1 + d;
				hi = sum[IN_COORD_W] ? '1 : sum[IN_COORD_W-1:0];
			end
		end else if (pick < 55) begin
			lo = booked_lo[k];
			hi = booked_hi[k];
		end else if (pick < 70) begin
			// butt up against a stored edge
			d = $urandom_range(1, 1 << $urandom_range(0, 16));
			if ($urandom_range(0, 1)) begin
				lo = booked_hi[k];
				hi = lo + d;
			end else begin
				hi = booked_lo[k];
				lo = hi - d;
			end
		end else if (pick < 85) begin
			lo = $urandom;
			hi = lo + $urandom_range(1, 1 << $urandom_range(0, 24));
		end else if (pick < 92) begin
			lo = $urandom;
			hi = $urandom_range(0, 1) ? lo : lo - $urandom_range(1, 32'hFFFF_FFFF);
		end else begin
			lo = $urandom;
			hi = $urandom;
		end
	endfunction

	// one request beat; expectation is queued at the accepting edge
	task automatic offer_request(input request_row_t row);
		booking_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.hi, row.lo};
		do @(posedge clk); while (!s_tready);
		predicted = book_range(row.lo, row.hi);
		owed_results.push_back(row.fixed ? row.result : predicted);
		@(negedge clk);
	endtask

	// directed requests, walked in order from reset
	request_row_t directed[] = '{
		// empty range on an empty table is always stored
		'{32'h0000_0005, 32'h0000_0005, 1'b1, '{STATUS_ACCEPT,  7'd1}},
		// inverted range at the extremes can never overlap
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{STATUS_ACCEPT,  7'd2}},
		// strictly contains the empty entry at 5
		'{32'h0000_0000, 32'h0000_000A, 1'b1, '{STATUS_OVERLAP, 7'd2}},
		// ends where the empty entry sits, no overlap
		'{32'h0000_0000, 32'h0000_0005, 1'b1, '{STATUS_ACCEPT,  7'd3}},
		'{32'h0000_0005, 32'h0000_0006, 1'b1, '{STATUS_ACCEPT,  7'd4}},
		'{32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, '{STATUS_ACCEPT,  7'd5}},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{STATUS_OVERLAP, 7'd5}},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{STATUS_OVERLAP, 7'd5}},
		'{32'h8000_0000, 32'h8000_0001, 1'b0, '{STATUS_ACCEPT,  7'd0}},
		'{32'h9000_0000, 32'h1000_0000, 1'b0, '{STATUS_ACCEPT,  7'd0}},
		'{32'h0000_0003, 32'h0000_0003, 1'b0, '{STATUS_ACCEPT,  7'd0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{STATUS_ACCEPT,  7'd0}},
		'{32'h0000_0000, 32'h0000_0000, 1'b0, '{STATUS_ACCEPT,  7'd0}},
		'{32'h8000_0000, 32'h8000_0001, 1'b0, '{STATUS_ACCEPT,  7'd0}}
	};

	// request side
	initial begin
		request_row_t row;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i])
			offer_request(directed[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_off_due = 1'b1;
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			draw_request(row.lo, row.hi);
			row.fixed = 1'b0;
			row.result = '0;
			offer_request(row);
		end
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		// stray beats after the last one would show up here
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_interval_reservation_table_core OK");
		else
			$display("tb_interval_reservation_table_core NOT OK");
		$finish;
	end

	// result side: random stalls, one long hold-off while requests keep coming
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	// compare each result beat with the oldest owed result
	always @(posedge clk) begin
		booking_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beat_count++;
			if (owed_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("beat %0d: unexpected result, status %0d used %0d",
						beat_count, m_tdata[STATUS_W-1:0],
						m_tdata[STATUS_W+USED_W-1:STATUS_W]);
			end else begin
				want = owed_results.pop_front();
				if (m_tdata[STATUS_W-1:0] !== want.status ||
						m_tdata[STATUS_W+USED_W-1:STATUS_W] !== want.used ||
						m_tdata[M_TDATA_W-1:STATUS_W+USED_W] !== {PAD_W{1'b0}}) begin
					fail_count++;
					if (fail_count <= 10)
						$display("beat %0d: expected status %0d used %0d, got status %0d used %0d pad %0h",
							beat_count, want.status, want.used, m_tdata[STATUS_W-1:0],
							m_tdata[STATUS_W+USED_W-1:STATUS_W],
							m_tdata[M_TDATA_W-1:STATUS_W+USED_W]);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("tb_interval_reservation_table_core NOT OK");
		$finish;
	end

endmodule
